FILE: hdl/text_console_writer_unit_assert.svh
// Assertion macros for the text console writer.
// Included by the top level; depends on nothing else.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TCW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Used by tcw_ctrl, tcw_datapath, text_console_writer_unit and the bench; no dependencies.
package tcw_pkg;

  // Field widths of the item and result ports
  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int TCOL_W    = 7;
  localparam int TROW_W    = 5;
  localparam int COLOR_W   = 8;
  localparam int PINNED_W  = 5;
  localparam int CELL_W    = CHAR_W + COLOR_W;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_TEXT_COLOR  = 1'b0;
  localparam logic REG_PINNED_ROWS = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  // Reset values
  localparam logic [COLOR_W-1:0]  RESET_COLOR  = 8'd15;
  localparam logic [PINNED_W-1:0] RESET_PINNED = 5'd0;

  // Item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_CHAR   = 2'd0,
    CMD_SET_CURSOR = 2'd1,
    CMD_CLEAR      = 2'd2,
    CMD_READ_CELL  = 2'd3
  } cmd_t;

  // Address counter operations
  typedef enum logic [2:0] {
    ADDR_HOLD,
    ADDR_ZERO,
    ADDR_SCROLL,
    ADDR_LAST_ROW,
    ADDR_INC
  } addr_op_t;

  // Screen store write selection
  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_BLANK,
    WR_COPY,
    WR_CHAR,
    WR_TAB
  } wr_sel_t;

  // Screen store read selection
  typedef enum logic [1:0] {
    RD_NONE,
    RD_SCROLL,
    RD_TARGET
  } rd_sel_t;

  // Cursor updates
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_SET,
    CUR_NEWLINE,
    CUR_COL0,
    CUR_INC,
    CUR_TAB
  } cur_op_t;

  // Controller to datapath
  typedef struct packed {
    logic     capture;
    addr_op_t addr_op;
    wr_sel_t  wr_sel;
    rd_sel_t  rd_sel;
    cur_op_t  cur_op;
    logic     tab_load;
    logic     tab_inc;
    logic     out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic is_newline;
    logic is_return;
    logic is_tab;
    logic wrap_pending;
    logic row_last;
    logic scroll_ok;
    logic addr_last;
    logic tab_in_row;
    logic tab_last;
    logic out_busy;
  } dp_sts_t;

endpackage

FILE: hdl/tcw_datapath.sv
// Datapath of the text console writer: captured item, cursor, address counter,
// screen store and result register. Depends on tcw_pkg.
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tcw_pkg::ctrl_cmd_t              ctl,
  output tcw_pkg::dp_sts_t                sts,
  input  logic [tcw_pkg::CMD_W-1:0]       in_cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]      in_char_code,
  input  logic [tcw_pkg::TCOL_W-1:0]      in_target_col,
  input  logic [tcw_pkg::TROW_W-1:0]      in_target_row,
  input  logic [tcw_pkg::COLOR_W-1:0]     text_color,
  input  logic [tcw_pkg::PINNED_W-1:0]    pinned_rows,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [tcw_pkg::TCOL_W-1:0]      out_cursor_col_out,
  output logic [tcw_pkg::TROW_W-1:0]      out_cursor_row_out,
  output logic [tcw_pkg::CHAR_W-1:0]      out_cell_char,
  output logic [tcw_pkg::COLOR_W-1:0]     out_cell_color
);

  localparam int NCELLS = COLUMNS * ROWS;
  localparam int AW     = $clog2(NCELLS);
  localparam int CW     = $clog2(COLUMNS + 1);
  localparam int RW     = $clog2(ROWS);
  localparam int TW     = $clog2(COLUMNS + 5);
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] LAST_CELL     = AW'(NCELLS - 1);

  // Captured item
  tcw_pkg::cmd_t               cmd_r;
  logic [tcw_pkg::CHAR_W-1:0]  char_r;
  logic [CW-1:0]               tcol_r;
  logic [RW-1:0]               trow_r;

  // Cursor, sweep address, tab column
  logic [CW-1:0] cursor_col_r, cursor_col_nxt;
  logic [RW-1:0] cursor_row_r, cursor_row_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [TW-1:0] tab_col_r;

  // Screen store
  logic [tcw_pkg::CELL_W-1:0] screen_mem [NCELLS];
  logic [tcw_pkg::CELL_W-1:0] rdata_r;
  logic                       mem_we, mem_re;
  logic [AW-1:0]              waddr, raddr;
  logic [tcw_pkg::CELL_W-1:0] wdata;

  // Result register
  logic                         out_valid_r, out_valid_nxt;
  logic [tcw_pkg::TCOL_W-1:0]   out_col_r;
  logic [tcw_pkg::TROW_W-1:0]   out_row_r;
  logic [tcw_pkg::CHAR_W-1:0]   out_char_r;
  logic [tcw_pkg::COLOR_W-1:0]  out_color_r;

  logic [CW-1:0] tcol_sat;
  logic [RW-1:0] trow_sat;
  logic [5:0]    frz_p1;
  logic [AW-1:0] scroll_base, cur_addr, tab_addr, tgt_addr;
  logic [TW-1:0] tab_stop, tab_wrap;
  logic          row_last;

  function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] col,
                                              input logic [AW-1:0] row);
    return col + AW'(COLUMNS) * row;
  endfunction

  // Saturate target coordinates to the grid
  assign tcol_sat = ({1'b0, in_target_col} > 8'(COLUMNS - 1)) ? CW'(COLUMNS - 1)
                                                              : CW'(in_target_col);
  assign trow_sat = ({1'b0, in_target_row} > 6'(ROWS - 1)) ? RW'(ROWS - 1)
                                                           : RW'(in_target_row);

  // Addresses
  assign frz_p1      = {1'b0, pinned_rows} + 6'd1;
  assign scroll_base = AW'(COLUMNS) * AW'(frz_p1);
  assign cur_addr    = cell_addr(AW'(cursor_col_r), AW'(cursor_row_r));
  assign tab_addr    = cell_addr(AW'(tab_col_r), AW'(cursor_row_r));
  assign tgt_addr    = cell_addr(AW'(tcol_r), AW'(trow_r));

  // Tab stop wraps modulo the row width; it never reaches twice the width
  assign tab_stop = tab_col_r + TW'(1);
  assign tab_wrap = (tab_stop >= TW'(COLUMNS)) ? tab_stop - TW'(COLUMNS) : tab_stop;
  assign row_last = (cursor_row_r == RW'(ROWS - 1));

  // Status
  always_comb begin
    sts.cmd          = cmd_r;
    sts.is_newline   = (char_r == tcw_pkg::CH_NEWLINE);
    sts.is_return    = (char_r == tcw_pkg::CH_RETURN);
    sts.is_tab       = (char_r == tcw_pkg::CH_TAB);
    sts.wrap_pending = (cursor_col_r >= CW'(COLUMNS));
    sts.row_last     = row_last;
    sts.scroll_ok    = (7'(frz_p1) < 7'(ROWS));
    sts.addr_last    = (addr_r == LAST_CELL);
    sts.tab_in_row   = (tab_col_r < TW'(COLUMNS));
    sts.tab_last     = (tab_col_r[1:0] == 2'b11);
    sts.out_busy     = out_valid_r && out_stall;
  end

  // Item capture and tab column (payload)
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= tcw_pkg::cmd_t'(in_cmd);
      char_r <= in_char_code;
      tcol_r <= tcol_sat;
      trow_r <= trow_sat;
    end
    if (ctl.tab_load) begin
      tab_col_r <= TW'(cursor_col_r);
    end else if (ctl.tab_inc) begin
      tab_col_r <= tab_col_r + TW'(1);
    end
  end

  // Cursor update
  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    case (ctl.cur_op)
      tcw_pkg::CUR_SET: begin
        cursor_col_nxt = tcol_r;
        cursor_row_nxt = trow_r;
      end
      tcw_pkg::CUR_NEWLINE: begin
        cursor_col_nxt = '0;
        if (!row_last) begin
          cursor_row_nxt = cursor_row_r + RW'(1);
        end
      end
      tcw_pkg::CUR_COL0: cursor_col_nxt = '0;
      tcw_pkg::CUR_INC:  cursor_col_nxt = cursor_col_r + CW'(1);
      tcw_pkg::CUR_TAB:  cursor_col_nxt = CW'(tab_wrap);
      default: ;
    endcase
  end

  // Sweep address counter
  always_comb begin
    case (ctl.addr_op)
      tcw_pkg::ADDR_ZERO:     addr_nxt = '0;
      tcw_pkg::ADDR_SCROLL:   addr_nxt = scroll_base;
      tcw_pkg::ADDR_LAST_ROW: addr_nxt = LAST_ROW_BASE;
      tcw_pkg::ADDR_INC:      addr_nxt = addr_r + AW'(1);
      default:                addr_nxt = addr_r;
    endcase
  end

  // Store write port
  always_comb begin
    mem_we = 1'b0;
    waddr  = addr_r;
    wdata  = {text_color, tcw_pkg::CH_SPACE};
    case (ctl.wr_sel)
      tcw_pkg::WR_INIT: begin
        mem_we = 1'b1;
        wdata  = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE};
      end
      tcw_pkg::WR_BLANK: mem_we = 1'b1;
      tcw_pkg::WR_COPY: begin
        mem_we = 1'b1;
        waddr  = addr_r - AW'(COLUMNS);
        wdata  = rdata_r;
      end
      tcw_pkg::WR_CHAR: begin
        mem_we = 1'b1;
        waddr  = cur_addr;
        wdata  = {text_color, char_r};
      end
      tcw_pkg::WR_TAB: begin
        mem_we = 1'b1;
        waddr  = tab_addr;
      end
      default: ;
    endcase
  end

  // Store read port
  always_comb begin
    mem_re = 1'b0;
    raddr  = addr_r;
    case (ctl.rd_sel)
      tcw_pkg::RD_SCROLL: mem_re = 1'b1;
      tcw_pkg::RD_TARGET: begin
        mem_re = 1'b1;
        raddr  = tgt_addr;
      end
      default: ;
    endcase
  end

  // Screen store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= screen_mem[raddr];
    end
  end

  // Result register: loaded only when the slot is free or being taken
  assign out_valid_nxt = ctl.out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_col_r <= tcw_pkg::TCOL_W'(cursor_col_r);
      out_row_r <= tcw_pkg::TROW_W'(cursor_row_r);
      if (cmd_r == tcw_pkg::CMD_READ_CELL) begin
        out_char_r  <= rdata_r[tcw_pkg::CHAR_W-1:0];
        out_color_r <= rdata_r[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
      end else begin
        out_char_r  <= '0;
        out_color_r <= '0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      addr_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      addr_r       <= addr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_col_out = out_col_r;
  assign out_cursor_row_out = out_row_r;
  assign out_cell_char      = out_char_r;
  assign out_cell_color     = out_color_r;

endmodule

FILE: hdl/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Drives tcw_datapath through ctrl_cmd_t; depends on tcw_pkg.
module tcw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tcw_pkg::dp_sts_t     sts,
  output tcw_pkg::ctrl_cmd_t   ctl
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_SCROLL_RD,
    S_SCROLL_WR,
    S_BLANK,
    S_PUT,
    S_TAB,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Items are taken only in idle
  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      // Clearing pass after reset
      S_INIT: begin
        ctl.wr_sel = tcw_pkg::WR_INIT;
        if (sts.addr_last) begin
          state_nxt = S_IDLE;
        end else begin
          ctl.addr_op = tcw_pkg::ADDR_INC;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.cmd)
          tcw_pkg::CMD_SET_CURSOR: begin
            ctl.cur_op = tcw_pkg::CUR_SET;
            state_nxt  = S_DONE;
          end
          tcw_pkg::CMD_CLEAR: begin
            ctl.addr_op = tcw_pkg::ADDR_ZERO;
            state_nxt   = S_CLEAR;
          end
          tcw_pkg::CMD_READ_CELL: begin
            ctl.rd_sel = tcw_pkg::RD_TARGET;
            state_nxt  = S_DONE;
          end
          default: begin
            if (sts.is_return) begin
              ctl.cur_op = tcw_pkg::CUR_COL0;
              state_nxt  = S_DONE;
            end else if (sts.is_tab) begin
              ctl.tab_load = 1'b1;
              state_nxt    = S_TAB;
            end else if (sts.is_newline || sts.wrap_pending) begin
              ctl.cur_op = tcw_pkg::CUR_NEWLINE;
              if (!sts.row_last) begin
                state_nxt = sts.is_newline ? S_DONE : S_PUT;
              end else if (sts.scroll_ok) begin
                ctl.addr_op = tcw_pkg::ADDR_SCROLL;
                state_nxt   = S_SCROLL_RD;
              end else begin
                ctl.addr_op = tcw_pkg::ADDR_LAST_ROW;
                state_nxt   = S_BLANK;
              end
            end else begin
              state_nxt = S_PUT;
            end
          end
        endcase
      end
      S_CLEAR: begin
        ctl.wr_sel = tcw_pkg::WR_BLANK;
        if (sts.addr_last) begin
          state_nxt = S_DONE;
        end else begin
          ctl.addr_op = tcw_pkg::ADDR_INC;
        end
      end
      // Scroll: read a cell, write it one row up
      S_SCROLL_RD: begin
        ctl.rd_sel = tcw_pkg::RD_SCROLL;
        state_nxt  = S_SCROLL_WR;
      end
      S_SCROLL_WR: begin
        ctl.wr_sel = tcw_pkg::WR_COPY;
        if (sts.addr_last) begin
          ctl.addr_op = tcw_pkg::ADDR_LAST_ROW;
          state_nxt   = S_BLANK;
        end else begin
          ctl.addr_op = tcw_pkg::ADDR_INC;
          state_nxt   = S_SCROLL_RD;
        end
      end
      // Blank the last row, then finish the deferred character if any
      S_BLANK: begin
        ctl.wr_sel = tcw_pkg::WR_BLANK;
        if (sts.addr_last) begin
          state_nxt = sts.is_newline ? S_DONE : S_PUT;
        end else begin
          ctl.addr_op = tcw_pkg::ADDR_INC;
        end
      end
      S_PUT: begin
        ctl.wr_sel = tcw_pkg::WR_CHAR;
        ctl.cur_op = tcw_pkg::CUR_INC;
        state_nxt  = S_DONE;
      end
      // One space per cycle up to the next tab stop, written only inside the row
      S_TAB: begin
        ctl.wr_sel  = sts.tab_in_row ? tcw_pkg::WR_TAB : tcw_pkg::WR_NONE;
        ctl.tab_inc = 1'b1;
        if (sts.tab_last) begin
          ctl.cur_op = tcw_pkg::CUR_TAB;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/text_console_writer_unit.sv
// Top level of the text console writer: configuration registers, controller
// and datapath. Depends on tcw_pkg, tcw_ctrl, tcw_datapath and the assert header.
//
// Usage: one item on the in_ channel (put char, set cursor, clear, read cell)
// gives one result on the out_ channel: cursor after the command and, for a
// read, the addressed cell. An item is taken when in_valid is high and
// in_stall low; a result moves when out_valid is high and out_stall low.
// From accept, set cursor, return, newline without scroll and read pass
// decode and done; a printable byte adds a put step, and a tab a step per
// tab cell. The next item can be taken in the same cycle as out_valid rises.
// Clear walks the store one cell a cycle. A scroll copies each cell with a
// read step and then a write step through the single store port pair, and
// blanks the last row one cell a cycle.
// After reset a clearing pass fills the store with spaces in color 15;
// in_stall stays high until it ends. Configuration writes are taken at any
// time. A stalled result holds in the output register while the next item
// is taken and worked; that item then waits for the slot.
`include "text_console_writer_unit_assert.svh"

module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Item channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]           in_cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]          in_char_code,
  input  logic [tcw_pkg::TCOL_W-1:0]          in_target_col,
  input  logic [tcw_pkg::TROW_W-1:0]          in_target_row,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tcw_pkg::TCOL_W-1:0]          out_cursor_col_out,
  output logic [tcw_pkg::TROW_W-1:0]          out_cursor_row_out,
  output logic [tcw_pkg::CHAR_W-1:0]          out_cell_char,
  output logic [tcw_pkg::COLOR_W-1:0]         out_cell_color,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  logic [tcw_pkg::COLOR_W-1:0]  text_color_r;
  logic [tcw_pkg::PINNED_W-1:0] pinned_rows_r;
  logic                         cfg_wr;
  logic                         reg_sel;

  tcw_pkg::ctrl_cmd_t ctl;
  tcw_pkg::dp_sts_t   sts;

  // Register file: index from the word address
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r  <= tcw_pkg::RESET_COLOR;
      pinned_rows_r <= tcw_pkg::RESET_PINNED;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        tcw_pkg::REG_TEXT_COLOR:  text_color_r  <= pwdata[tcw_pkg::COLOR_W-1:0];
        tcw_pkg::REG_PINNED_ROWS: pinned_rows_r <= pwdata[tcw_pkg::PINNED_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_sel)
      tcw_pkg::REG_TEXT_COLOR:  prdata = tcw_pkg::CFG_DATA_W'(text_color_r);
      tcw_pkg::REG_PINNED_ROWS: prdata = tcw_pkg::CFG_DATA_W'(pinned_rows_r);
      default:                  prdata = '0;
    endcase
  end

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .in_cmd             (in_cmd),
    .in_char_code       (in_char_code),
    .in_target_col      (in_target_col),
    .in_target_row      (in_target_row),
    .text_color         (text_color_r),
    .pinned_rows        (pinned_rows_r),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_cursor_col_out (out_cursor_col_out),
    .out_cursor_row_out (out_cursor_row_out),
    .out_cell_char      (out_cell_char),
    .out_cell_color     (out_cell_color)
  );

  // An accepted item keeps the block busy for at least the next cycle
  `TCW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "item accepted but block not busy next cycle")

  // Reported cursor stays within the grid (column may show a pending wrap)
  `TCW_ASSERT_SAME(a_cursor_in_grid, clk, rst_n, out_valid, (32'(out_cursor_row_out) < ROWS) && (32'(out_cursor_col_out) <= COLUMNS), "cursor outside the grid")

endmodule

FILE: bench/text_console_writer_unit_tb.sv
// Self-checking bench for text_console_writer_unit: directed and random items
// checked against an in-bench screen/cursor predictor. Depends on tcw_pkg.
// Sender bursts, receiver stall patterns and APB register phases are built in.
module testbench;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int TAB_STOP    = 4;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 130;
  // Sized for a full scroll on every item, plus stalls
  localparam int CYCLE_LIMIT = 25_000_000;
  localparam logic [tcw_pkg::CFG_ADDR_W-1:0] ADDR_TEXT_COLOR  =
    {tcw_pkg::REG_TEXT_COLOR, 2'b00};
  localparam logic [tcw_pkg::CFG_ADDR_W-1:0] ADDR_PINNED_ROWS =
    {tcw_pkg::REG_PINNED_ROWS, 2'b00};

  typedef struct {
    tcw_pkg::cmd_t                     cmd;
    logic [tcw_pkg::CHAR_W-1:0]        chr;
    logic [tcw_pkg::TCOL_W-1:0]        tcol;
    logic [tcw_pkg::TROW_W-1:0]        trow;
  } item_t;

  typedef struct {
    logic [tcw_pkg::TCOL_W-1:0]        col;
    logic [tcw_pkg::TROW_W-1:0]        row;
    logic [tcw_pkg::CHAR_W-1:0]        chr;
    logic [tcw_pkg::COLOR_W-1:0]       attr;
  } report_t;

  typedef struct {
    item_t   it;
    bit      typed;
    report_t rep;
  } stim_row_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [tcw_pkg::CMD_W-1:0] in_cmd = '0;
  logic [tcw_pkg::CHAR_W-1:0] in_char_code = '0;
  logic [tcw_pkg::TCOL_W-1:0] in_target_col = '0;
  logic [tcw_pkg::TROW_W-1:0] in_target_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [tcw_pkg::TCOL_W-1:0] out_cursor_col_out;
  logic [tcw_pkg::TROW_W-1:0] out_cursor_row_out;
  logic [tcw_pkg::CHAR_W-1:0] out_cell_char;
  logic [tcw_pkg::COLOR_W-1:0] out_cell_color;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tcw_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [tcw_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [tcw_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  // Predictor state: screen store, cursor and register copies
  logic [tcw_pkg::CELL_W-1:0] screen_mem [0:SCREEN_COLS*SCREEN_ROWS-1];
  int cur_col;
  int cur_row;
  logic [tcw_pkg::COLOR_W-1:0] text_color;
  logic [tcw_pkg::PINNED_W-1:0] pinned_rows;

  report_t expected_reports[$];
  stim_row_t directed_rows[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_run = 0;

  text_console_writer_unit #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_char_code      (in_char_code),
    .in_target_col     (in_target_col),
    .in_target_row     (in_target_row),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_col_out(out_cursor_col_out),
    .out_cursor_row_out(out_cursor_row_out),
    .out_cell_char     (out_cell_char),
    .out_cell_color    (out_cell_color),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  // Fill a whole row with spaces in the current color
  function automatic void blank_line(int r);
    int c;
    for (c = 0; c < SCREEN_COLS; c++)
      screen_mem[r*SCREEN_COLS + c] = {text_color, tcw_pkg::CH_SPACE};
  endfunction

  // Newline: next row, or scroll the unpinned rows up and blank the bottom
  function automatic void line_feed();
    int r;
    int c;
    cur_col = 0;
    if (cur_row < SCREEN_ROWS - 1) begin
      cur_row++;
    end else begin
      for (r = 1 + int'(pinned_rows); r < SCREEN_ROWS; r++)
        for (c = 0; c < SCREEN_COLS; c++)
          screen_mem[(r-1)*SCREEN_COLS + c] = screen_mem[r*SCREEN_COLS + c];
      blank_line(SCREEN_ROWS - 1);
    end
  endfunction

  // Apply one item to the predicted console and return its report
  function automatic report_t console_step(item_t it);
    report_t rep;
    int tc;
    int tr;
    int stop;
    int c;
    logic [tcw_pkg::CELL_W-1:0] cell_val;
    rep = '{default: '0};
    tc = (it.tcol > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : int'(it.tcol);
    tr = (it.trow > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : int'(it.trow);
    case (it.cmd)
      tcw_pkg::CMD_PUT_CHAR: begin
        if (it.chr == tcw_pkg::CH_NEWLINE) begin
          line_feed();
        end else if (it.chr == tcw_pkg::CH_RETURN) begin
          cur_col = 0;
        end else if (it.chr == tcw_pkg::CH_TAB) begin
          // spaces only inside the row, then wrap the column
          stop = cur_col + (TAB_STOP - cur_col % TAB_STOP);
          for (c = cur_col; c < stop; c++)
            if (c < SCREEN_COLS)
              screen_mem[cur_row*SCREEN_COLS + c] = {text_color, tcw_pkg::CH_SPACE};
          cur_col = stop % SCREEN_COLS;
        end else begin
          if (cur_col >= SCREEN_COLS) line_feed();
          screen_mem[cur_row*SCREEN_COLS + cur_col] = {text_color, it.chr};
          cur_col++;
        end
      end
      tcw_pkg::CMD_SET_CURSOR: begin
        cur_col = tc;
        cur_row = tr;
      end
      tcw_pkg::CMD_CLEAR: begin
        for (c = 0; c < SCREEN_ROWS; c++) blank_line(c);
      end
      default: begin
        cell_val = screen_mem[tr*SCREEN_COLS + tc];
        rep.chr = cell_val[tcw_pkg::CHAR_W-1:0];
        rep.attr = cell_val[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
      end
    endcase
    rep.col = cur_col[tcw_pkg::TCOL_W-1:0];
    rep.row = cur_row[tcw_pkg::TROW_W-1:0];
    return rep;
  endfunction

  task automatic check_field(string name, int expv, int actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, actv);
      mismatch_count++;
    end
  endtask

  // Random item, mostly well-formed text with cursor moves and reads
  function automatic item_t random_item();
    item_t it;
    int sel;
    int k;
    sel = $urandom_range(0, 99);
    it.chr = 8'($urandom_range(0, 255));
    it.tcol = 7'($urandom_range(0, 127));
    it.trow = 5'($urandom_range(0, 31));
    if (sel < 52) begin
      it.cmd = tcw_pkg::CMD_PUT_CHAR;
      k = $urandom_range(0, 99);
      if (k < 14) it.chr = tcw_pkg::CH_NEWLINE;
      else if (k < 20) it.chr = tcw_pkg::CH_RETURN;
      else if (k < 30) it.chr = tcw_pkg::CH_TAB;
    end else if (sel < 68) begin
      it.cmd = tcw_pkg::CMD_SET_CURSOR;
      k = $urandom_range(0, 99);
      if (k < 30) it.tcol = 7'($urandom_range(SCREEN_COLS - 4, 127));
      else if (k < 80) it.tcol = 7'($urandom_range(0, SCREEN_COLS - 1));
      k = $urandom_range(0, 99);
      if (k < 40) it.trow = 5'($urandom_range(SCREEN_ROWS - 3, SCREEN_ROWS - 1));
      else if (k < 90) it.trow = 5'($urandom_range(0, SCREEN_ROWS - 1));
    end else if (sel < 98) begin
      it.cmd = tcw_pkg::CMD_READ_CELL;
      if ($urandom_range(0, 4) != 0) begin
        it.tcol = 7'($urandom_range(0, SCREEN_COLS - 1));
        it.trow = 5'($urandom_range(0, SCREEN_ROWS - 1));
      end
    end else begin
      it.cmd = tcw_pkg::CMD_CLEAR;
    end
    return it;
  endfunction

  task automatic add_row(tcw_pkg::cmd_t cmd, logic [tcw_pkg::CHAR_W-1:0] chr,
                         logic [tcw_pkg::TCOL_W-1:0] tcol,
                         logic [tcw_pkg::TROW_W-1:0] trow, bit typed, int ecol = 0,
                         int erow = 0, int echr = 0, int eattr = 0);
    stim_row_t s;
    s.it = '{cmd: cmd, chr: chr, tcol: tcol, trow: trow};
    s.typed = typed;
    s.rep = '{col: 7'(ecol), row: 5'(erow), chr: 8'(echr), attr: 8'(eattr)};
    directed_rows.push_back(s);
  endtask

  // Present one item, wait for the handshake, record what it should produce
  task automatic send_item(item_t it, bit typed, report_t typed_rep);
    report_t rep;
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= it.cmd;
    in_char_code <= it.chr;
    in_target_col <= it.tcol;
    in_target_row <= it.trow;
    do @(posedge clk); while (in_stall);
    rep = console_step(it);
    expected_reports.push_back(typed ? typed_rep : rep);
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Bursts of random length separated by random gaps
  task automatic pace_sender();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      idle_gap($urandom_range(1, 10));
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
    end
  endtask

  // One APB transfer; a write updates the predictor, a read checks prdata
  task automatic cfg_access(bit wr, logic [tcw_pkg::CFG_ADDR_W-1:0] addr,
                            logic [tcw_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      if (addr == ADDR_TEXT_COLOR) text_color = data[tcw_pkg::COLOR_W-1:0];
      else pinned_rows = data[tcw_pkg::PINNED_W-1:0];
    end else begin
      check_field(addr == ADDR_TEXT_COLOR ? "text_color readback" : "pinned_rows readback",
                  data, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_registers(logic [tcw_pkg::COLOR_W-1:0] color,
                               logic [tcw_pkg::PINNED_W-1:0] pinned);
    cfg_access(1'b1, ADDR_TEXT_COLOR, 32'(color));
    cfg_access(1'b0, ADDR_TEXT_COLOR, 32'(color));
    cfg_access(1'b1, ADDR_PINNED_ROWS, 32'(pinned));
    cfg_access(1'b0, ADDR_PINNED_ROWS, 32'(pinned));
  endtask

  // Result check against the oldest expectation
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result with nothing expected: col %0d row %0d char %0d color %0d",
                 $time, out_cursor_col_out, out_cursor_row_out, out_cell_char, out_cell_color);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("cursor_col_out", int'(want.col), int'(out_cursor_col_out));
        check_field("cursor_row_out", int'(want.row), int'(out_cursor_row_out));
        check_field("cell_char", int'(want.chr), int'(out_cell_char));
        check_field("cell_color", int'(want.attr), int'(out_cell_color));
      end
    end
  end

  // Receiver stall pattern: quiet runs, light and heavy random, solid holds
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_run = (stall_mode == STALL_HOLD) ? $urandom_range(1, 6) : $urandom_range(10, 60);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= 1'b1;
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** text_console_writer_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int i;
    int phase;
    logic [tcw_pkg::COLOR_W-1:0] color;
    logic [tcw_pkg::PINNED_W-1:0] pinned;
    report_t none;

    none = '{default: '0};
    for (i = 0; i < SCREEN_COLS*SCREEN_ROWS; i++)
      screen_mem[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE};
    cur_col = 0;
    cur_row = 0;
    text_color = tcw_pkg::RESET_COLOR;
    pinned_rows = tcw_pkg::RESET_PINNED;

    // Directed stimulus; typed expectations where obvious, else predicted
    add_row(tcw_pkg::CMD_READ_CELL, 8'h00, 7'd0, 5'd0, 1, 0, 0,
            tcw_pkg::CH_SPACE, tcw_pkg::RESET_COLOR);
    add_row(tcw_pkg::CMD_READ_CELL, 8'hFF, 7'd127, 5'd31, 1, 0, 0,
            tcw_pkg::CH_SPACE, tcw_pkg::RESET_COLOR);
    add_row(tcw_pkg::CMD_SET_CURSOR, 8'h00, 7'd127, 5'd31, 1, 79, 24);
    add_row(tcw_pkg::CMD_PUT_CHAR, 8'h41, 7'd0, 5'd0, 1, 80, 24);   // lands in last column
    add_row(tcw_pkg::CMD_PUT_CHAR, 8'hFF, 7'd127, 5'd31, 1, 1, 24); // wrap scrolls
    add_row(tcw_pkg::CMD_READ_CELL, 8'h00, 7'd79, 5'd23, 1, 1, 24, 8'h41,
            tcw_pkg::RESET_COLOR);
    add_row(tcw_pkg::CMD_READ_CELL, 8'h00, 7'd0, 5'd24, 1, 1, 24, 8'hFF,
            tcw_pkg::RESET_COLOR);
    add_row(tcw_pkg::CMD_PUT_CHAR, 8'h00, 7'd0, 5'd0, 0);
    add_row(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_TAB, 7'd0, 5'd0, 0);
    add_row(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_RETURN, 7'd0, 5'd0, 1, 0, 24);
    add_row(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_NEWLINE, 7'd0, 5'd0, 0); // scroll on last row
    add_row(tcw_pkg::CMD_READ_CELL, 8'h00, 7'd0, 5'd23, 0);
    add_row(tcw_pkg::CMD_SET_CURSOR, 8'h00, 7'd78, 5'd3, 1, 78, 3);
    add_row(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_TAB, 7'd0, 5'd0, 0);     // tab past the edge
    add_row(tcw_pkg::CMD_READ_CELL, 8'h00, 7'd79, 5'd3, 0);
    add_row(tcw_pkg::CMD_SET_CURSOR, 8'h00, 7'd79, 5'd5, 1, 79, 5);
    add_row(tcw_pkg::CMD_PUT_CHAR, 8'h78, 7'd0, 5'd0, 1, 80, 5);
    add_row(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_TAB, 7'd0, 5'd0, 0);     // tab with wrap pending
    add_row(tcw_pkg::CMD_READ_CELL, 8'h00, 7'd0, 5'd5, 0);
    add_row(tcw_pkg::CMD_SET_CURSOR, 8'h00, 7'd0, 5'd0, 1, 0, 0);
    add_row(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_NEWLINE, 7'd0, 5'd0, 1, 0, 1);
    add_row(tcw_pkg::CMD_CLEAR, 8'hFF, 7'd127, 5'd31, 0);
    add_row(tcw_pkg::CMD_READ_CELL, 8'h00, 7'd79, 5'd24, 0);
    add_row(tcw_pkg::CMD_READ_CELL, 8'h00, 7'd79, 5'd5, 0);

    // Synchronous reset, then the block clears its store on its own
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].rep);
      pace_sender();
    end

    // Random phases, each under its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      color = 8'($urandom_range(0, 255));
      pinned = 5'($urandom_range(0, SCREEN_ROWS - 1));
      case (phase)
        0: begin color = 8'h00; pinned = 5'd0; end
        1: begin color = 8'hFF; pinned = 5'(SCREEN_ROWS - 1); end
        2: pinned = 5'(SCREEN_ROWS - 2);
        3: pinned = 5'd1;
        5: pinned = 5'd0;
        default: ;
      endcase
      idle_gap(1);
      while (expected_reports.size() != 0) @(posedge clk);
      set_registers(color, pinned);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_item(random_item(), 1'b0, none);
        pace_sender();
      end
    end

    // Drain and let the block settle
    idle_gap(1);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** text_console_writer_unit: PASSED **");
    end else begin
      $display("** text_console_writer_unit: FAILED **");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_datapath.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer_unit.sv
bench/text_console_writer_unit_tb.sv
